>>> rtl/ptt_pkg.sv
// shared types, field widths, command and status codes for the periodic timer table
`timescale 1ns / 1ps

package ptt_pkg;

  // request and result field widths
  localparam int CMD_W    = 3;
  localparam int INDEX_W  = 5;
  localparam int PERIOD_W = 16;
  localparam int GROUP_W  = 8;
  localparam int STATUS_W = 3;

  // parameter defaults
  localparam int NUM_TIMERS_DEF  = 32;
  localparam int PERIOD_BITS_DEF = 16;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [GROUP_W-1:0]  group_t;
  typedef logic [STATUS_W-1:0] status_t;

  // command codes
  localparam cmd_t CMD_TICK      = 3'd0;
  localparam cmd_t CMD_OPEN      = 3'd1;
  localparam cmd_t CMD_CLOSE     = 3'd2;
  localparam cmd_t CMD_ON        = 3'd3;
  localparam cmd_t CMD_OFF       = 3'd4;
  localparam cmd_t CMD_GROUP_ON  = 3'd5;
  localparam cmd_t CMD_GROUP_OFF = 3'd6;

  // result status codes
  localparam status_t ST_FIRE   = 3'd0;
  localparam status_t ST_NONE   = 3'd1;
  localparam status_t ST_OPENED = 3'd2;
  localparam status_t ST_FULL   = 3'd3;
  localparam status_t ST_DONE   = 3'd4;

endpackage

>>> rtl/ptt_req_if.sv
// request channel of the periodic timer table
`timescale 1ns / 1ps

interface ptt_req_if;
  logic             valid;
  logic             ready;
  ptt_pkg::cmd_t    cmd;
  ptt_pkg::index_t  timer_index;
  ptt_pkg::period_t period;
  ptt_pkg::group_t  group_id;

  modport source (output valid, output cmd, output timer_index, output period,
                  output group_id, input ready);
  modport sink (input valid, input cmd, input timer_index, input period,
                input group_id, output ready);
endinterface

>>> rtl/ptt_res_if.sv
// result channel of the periodic timer table
`timescale 1ns / 1ps

interface ptt_res_if;
  logic             valid;
  logic             ready;
  ptt_pkg::status_t status;
  ptt_pkg::index_t  result_index;
  logic             last;

  modport source (output valid, output status, output result_index, output last,
                  input ready);
  modport sink (input valid, input status, input result_index, input last,
                output ready);
endinterface

>>> rtl/periodic_timer_table_top.sv
// top level of the periodic timer table: command sequencer around the entry ram
`timescale 1ns / 1ps

// Periodic timer table with NUM_TIMERS entries. Each entry has a used and an
// active flag, held in flip-flops and cleared by reset, plus a period, a tick
// counter and a group number held in one entry ram with a registered read.
// Ram contents need no clearing pass: an entry is only looked at while its
// used flag is set, and open writes the whole entry. A request is taken
// whenever the sequencer is idle, even while the previous result waits in the
// output register. Open, close, on and off pass through the exec state, which
// loads their result into the output register. Tick, group on and group off
// sweep the ram one entry per cycle through its single read port. Either kind
// also waits every cycle that a result, a fire included, finds the output
// register still held by the consumer.
// A tick writes each advancing counter back after reading it, always to an
// entry other than the one being read, so no forwarding is needed. Fires come
// out in ascending index order; the final one carries last. A tick with no
// fire answers status none; every other request answers with one result.
module periodic_timer_table_top #(
  parameter int NUM_TIMERS  = ptt_pkg::NUM_TIMERS_DEF,
  parameter int PERIOD_BITS = ptt_pkg::PERIOD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ptt_req_if.sink   req,
  ptt_res_if.source res
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = IW + 1;
  localparam int GW = ptt_pkg::GROUP_W;
  localparam int XW = ptt_pkg::INDEX_W;
  localparam int PW = ptt_pkg::PERIOD_W;
  localparam int EW = 2 * PERIOD_BITS + GW;

  // entry layout in the ram: {period, count, group}
  localparam int CNT_LO = GW;
  localparam int PER_LO = GW + PERIOD_BITS;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  function automatic ptt_pkg::index_t to_index(input logic [IW-1:0] v);
    logic [IW+XW-1:0] w;
    w = {{XW{1'b0}}, v};
    return w[XW-1:0];
  endfunction

  logic [1:0]             state, state_next;
  logic [CW-1:0]          iss_cnt, iss_cnt_next;
  logic                   proc_valid, proc_valid_next;
  logic [IW-1:0]          proc_idx, proc_idx_next;
  logic                   pend_valid, pend_valid_next;
  logic [IW-1:0]          pend_idx, pend_idx_next;
  logic [NUM_TIMERS-1:0]  used, used_next;
  logic [NUM_TIMERS-1:0]  active, active_next;

  // captured request
  ptt_pkg::cmd_t          cmd_q;
  ptt_pkg::index_t        idx_q;
  logic [PERIOD_BITS-1:0] per_q;
  ptt_pkg::group_t        grp_q;

  // output register
  logic                   out_valid, out_valid_next;
  ptt_pkg::status_t       out_status, out_status_next;
  ptt_pkg::index_t        out_index, out_index_next;
  logic                   out_last, out_last_next;
  logic                   out_load;
  logic                   out_free;

  // ram ports
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic                   ram_re;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;

  logic                   accept;
  logic                   is_sweep;
  logic [PW+PERIOD_BITS-1:0] per_wide;

  // fields of the entry under processing
  ptt_pkg::group_t        e_grp;
  logic [PERIOD_BITS-1:0] e_cnt;
  logic [PERIOD_BITS-1:0] e_per;
  logic [PERIOD_BITS-1:0] e_cnt_inc;
  logic                   e_step;
  logic                   e_fire;
  logic                   stall;

  // addressed entry for close, on and off
  logic [IW+XW-1:0]       t_wide;
  logic [IW-1:0]          t_idx;
  logic                   t_in_range;

  // highest free entry for open
  logic                   free_found;
  logic [IW-1:0]          free_slot;

  ptt_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_TIMERS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign is_sweep  = (req.cmd == ptt_pkg::CMD_TICK) || (req.cmd == ptt_pkg::CMD_GROUP_ON) ||
                     (req.cmd == ptt_pkg::CMD_GROUP_OFF);
  assign per_wide  = {{PERIOD_BITS{1'b0}}, req.period};

  assign out_free  = !out_valid || res.ready;

  assign e_grp     = ram_rdata[GW-1:0];
  assign e_cnt     = ram_rdata[CNT_LO +: PERIOD_BITS];
  assign e_per     = ram_rdata[PER_LO +: PERIOD_BITS];
  assign e_cnt_inc = e_cnt + {{(PERIOD_BITS-1){1'b0}}, 1'b1};
  // period zero never advances
  assign e_step    = active[proc_idx] && (e_per != '0);
  assign e_fire    = e_step && (e_cnt_inc == e_per);
  // a second fire must push the held one out first
  assign stall     = proc_valid && (cmd_q == ptt_pkg::CMD_TICK) && e_fire && pend_valid &&
                     !out_free;

  assign t_wide     = {{IW{1'b0}}, idx_q};
  assign t_idx      = t_wide[IW-1:0];
  assign t_in_range = (t_wide < (IW+XW)'(NUM_TIMERS));

  // last free entry found wins, giving the highest index
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_slot  = IW'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    iss_cnt_next    = iss_cnt;
    proc_valid_next = proc_valid;
    proc_idx_next   = proc_idx;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    used_next       = used;
    active_next     = active;
    out_load        = 1'b0;
    out_status_next = out_status;
    out_index_next  = out_index;
    out_last_next   = out_last;
    ram_we          = 1'b0;
    ram_waddr       = proc_idx;
    ram_wdata       = ram_rdata;
    ram_re          = 1'b0;
    ram_raddr       = iss_cnt[IW-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next      = is_sweep ? S_SCAN : S_EXEC;
          iss_cnt_next    = '0;
          proc_valid_next = 1'b0;
          pend_valid_next = 1'b0;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = ptt_pkg::ST_DONE;
          out_index_next  = '0;
          out_last_next   = 1'b1;
          state_next      = S_IDLE;
          unique case (cmd_q) inside
            ptt_pkg::CMD_OPEN: begin
              if (free_found) begin
                used_next[free_slot]   = 1'b1;
                active_next[free_slot] = 1'b0;
                ram_we          = 1'b1;
                ram_waddr       = free_slot;
                ram_wdata       = {per_q, {PERIOD_BITS{1'b0}}, grp_q};
                out_status_next = ptt_pkg::ST_OPENED;
                out_index_next  = to_index(free_slot);
              end else begin
                out_status_next = ptt_pkg::ST_FULL;
              end
            end
            ptt_pkg::CMD_CLOSE: begin
              if (t_in_range) begin
                used_next[t_idx]   = 1'b0;
                active_next[t_idx] = 1'b0;
              end
            end
            ptt_pkg::CMD_ON, ptt_pkg::CMD_OFF: begin
              if (t_in_range && used[t_idx]) begin
                active_next[t_idx] = (cmd_q == ptt_pkg::CMD_ON);
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!stall) begin
          // read the next entry while the previous one is processed
          if (iss_cnt < CW'(NUM_TIMERS)) begin
            ram_re          = 1'b1;
            proc_valid_next = 1'b1;
            proc_idx_next   = iss_cnt[IW-1:0];
            iss_cnt_next    = iss_cnt + 1'b1;
          end else begin
            proc_valid_next = 1'b0;
          end
          if (proc_valid) begin
            if (cmd_q == ptt_pkg::CMD_TICK) begin
              if (e_step) begin
                ram_we    = 1'b1;
                ram_wdata = {e_per, (e_fire ? {PERIOD_BITS{1'b0}} : e_cnt_inc), e_grp};
              end
              if (e_fire) begin
                if (pend_valid) begin
                  out_load        = 1'b1;
                  out_status_next = ptt_pkg::ST_FIRE;
                  out_index_next  = to_index(pend_idx);
                  out_last_next   = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_idx_next   = proc_idx;
              end
            end else if (used[proc_idx] && (e_grp == grp_q)) begin
              active_next[proc_idx] = (cmd_q == ptt_pkg::CMD_GROUP_ON);
            end
          end else if (iss_cnt == CW'(NUM_TIMERS)) begin
            state_next = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_last_next   = 1'b1;
          out_index_next  = '0;
          state_next      = S_IDLE;
          pend_valid_next = 1'b0;
          if (cmd_q != ptt_pkg::CMD_TICK) begin
            out_status_next = ptt_pkg::ST_DONE;
          end else if (pend_valid) begin
            out_status_next = ptt_pkg::ST_FIRE;
            out_index_next  = to_index(pend_idx);
          end else begin
            out_status_next = ptt_pkg::ST_NONE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    out_valid_next = out_load || (out_valid && !res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      iss_cnt    <= '0;
      proc_valid <= 1'b0;
      pend_valid <= 1'b0;
      used       <= '0;
      active     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      iss_cnt    <= iss_cnt_next;
      proc_valid <= proc_valid_next;
      pend_valid <= pend_valid_next;
      used       <= used_next;
      active     <= active_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    proc_idx   <= proc_idx_next;
    pend_idx   <= pend_idx_next;
    out_status <= out_status_next;
    out_index  <= out_index_next;
    out_last   <= out_last_next;
    if (accept) begin
      cmd_q <= req.cmd;
      idx_q <= req.timer_index;
      per_q <= per_wide[PERIOD_BITS-1:0];
      grp_q <= req.group_id;
    end
  end

  assign res.valid        = out_valid;
  assign res.status       = out_status;
  assign res.result_index = out_index;
  assign res.last         = out_last;

`ifndef NO_ASSERTIONS
  // an active entry is always a used one
  a_active_used: assert property (@(posedge clk) disable iff (rst)
    (active & ~used) == '0)
    else $error("active flag set on an unused entry");

  // the sweep never reads the entry it is writing back
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("entry ram read and write to the same entry");

  // a held fire only exists during a tick sweep or its flush
  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ((state == S_SCAN || state == S_FLUSH) && cmd_q == ptt_pkg::CMD_TICK))
    else $error("held fire outside a tick");

  // a stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_status) && $stable(out_index)
                                   && $stable(out_last)))
    else $error("result register changed while stalled");
`endif

endmodule

>>> rtl/ptt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
